### rtl/core/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types, byte codes and limits for the multibulk request deframer.
// ----------------------------------------------------------------------------
package mrd_pkg;

  // Limits on argument length and argument count
  localparam int unsigned MAX_ARG_LEN = 16777216;
  localparam int unsigned MAX_ARGS    = 65536;
  localparam int unsigned NUM_CAP     = (MAX_ARG_LEN > MAX_ARGS) ? MAX_ARG_LEN : MAX_ARGS;

  // Number accumulator holds up to NUM_CAP + 1 (the saturated value)
  localparam int unsigned ACC_W  = $clog2(NUM_CAP + 2);
  localparam int unsigned PROD_W = ACC_W + 4;
  localparam int unsigned RADIX  = 10;

  // Payload widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned LEN_W   = 25;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned ERR_W   = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [ERR_W-1:0]  err_t;
  typedef logic [ACC_W-1:0]  acc_t;

  // Result kinds
  localparam kind_t KIND_ARG_BEGIN = 2'd0;
  localparam kind_t KIND_ARG_DATA  = 2'd1;
  localparam kind_t KIND_REQ_DONE  = 2'd2;
  localparam kind_t KIND_ERROR     = 2'd3;

  // Error codes
  localparam err_t ERR_NONE     = 3'd0;
  localparam err_t ERR_NO_STAR  = 3'd1;
  localparam err_t ERR_BAD_CNT  = 3'd2;
  localparam err_t ERR_NEG_LEN  = 3'd3;
  localparam err_t ERR_LEN_BIG  = 3'd4;

  // Byte codes
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_VT    = 8'h0B;
  localparam byte_t CH_FF    = 8'h0C;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_STAR  = 8'h2A;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;

  // Flags of the decimal number being read
  typedef struct packed {
    logic begun;
    logic neg;
    logic stop;
    logic ovf;
  } num_flags_t;

  // Deframer phase, one-hot
  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_COUNT  = 8'b0000_0010,
    PH_HFIRST = 8'b0000_0100,
    PH_HNUM   = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_TERM   = 8'b0010_0000,
    PH_OPTLF  = 8'b0100_0000,
    PH_HALT   = 8'b1000_0000
  } phase_t;

  // One result item
  typedef struct packed {
    kind_t            kind;
    byte_t            data_byte;
    logic [LEN_W-1:0] arg_length;
    logic [IDX_W-1:0] arg_index;
    logic             last_of_arg;
    logic [CNT_W-1:0] arg_count;
    err_t             error_code;
  } result_t;

endpackage

### rtl/core/mrd_stream_if.sv
// ----------------------------------------------------------------------------
// mrd_stream_if
// Valid/ready channels: raw request bytes in, deframer events out.
// ----------------------------------------------------------------------------
interface mrd_byte_if;
  import mrd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface mrd_event_if;
  import mrd_pkg::*;

  logic             valid;
  logic             ready;
  kind_t            kind;
  byte_t            data_byte;
  logic [LEN_W-1:0] arg_length;
  logic [IDX_W-1:0] arg_index;
  logic             last_of_arg;
  logic [CNT_W-1:0] arg_count;
  err_t             error_code;

  modport source (output valid, output kind, output data_byte, output arg_length,
                  output arg_index, output last_of_arg, output arg_count,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input data_byte, input arg_length,
                  input arg_index, input last_of_arg, input arg_count,
                  input error_code, output ready);
endinterface

### rtl/core/multibulk_request_deframer_top.sv
// ----------------------------------------------------------------------------
// multibulk_request_deframer_top
// Byte-wide multibulk request deframer with valid/ready channels.
// ----------------------------------------------------------------------------
// The block takes one request byte per clock cycle while events are taken, and
// returns at most one event per byte: argument begin, argument data byte,
// request done or error. Each byte passes through an input register, a
// single-pass update of the parser state, and a result register, and its
// event is offered once the result register holds it. The single-pass state
// update is what sets the rate of one byte per cycle. A byte in the input
// register moves on only when the result register is empty or its event is
// taken in the same cycle, so while the receiver holds off an event the block
// keeps one more byte and then stalls its input. After any error the block
// reports it once and then drops every byte until reset; there is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module multibulk_request_deframer_top (
  input logic               clk,
  input logic               rst,
  mrd_byte_if.sink          bytes,
  mrd_event_if.source       events
);
  import mrd_pkg::*;

  // Input register
  logic       in_v;
  byte_t      in_b;

  // Parser state
  phase_t           phase, phase_next;
  acc_t             acc, acc_next;
  num_flags_t       flags, flags_next;
  logic [CNT_W-1:0] args_remaining, args_remaining_next;
  logic [CNT_W-1:0] args_total, args_total_next;
  logic [IDX_W-1:0] current_arg, current_arg_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;

  // Result register
  logic    out_v;
  result_t res;
  result_t res_next;
  logic    res_fire;

  logic       advance;

  // Number feed
  acc_t       feed_acc;
  num_flags_t feed_flags;

  // Header completion inputs (cleared number when the header line is empty)
  acc_t       hd_acc;
  num_flags_t hd_flags;
  logic       hd_neg;
  logic [CNT_W-1:0] rem_dec;
  logic [LEN_W-1:0] br_dec;

  // Move the byte on when the result slot is free or being taken this cycle
  assign advance     = in_v && (!out_v || events.ready);
  assign bytes.ready = !in_v || advance;

  mrd_num_digit u_num (
    .b          (in_b),
    .acc        (acc),
    .flags      (flags),
    .acc_next   (feed_acc),
    .flags_next (feed_flags)
  );

  assign hd_acc   = (phase == PH_HFIRST) ? '0 : acc;
  assign hd_flags = (phase == PH_HFIRST) ? '0 : flags;
  assign hd_neg   = hd_flags.neg && (hd_acc != '0);
  assign rem_dec  = args_remaining - CNT_W'(1);
  assign br_dec   = bytes_remaining - LEN_W'(1);

  // Single-pass parser step on the registered byte
  always_comb begin
    phase_next           = phase;
    acc_next             = acc;
    flags_next           = flags;
    args_remaining_next  = args_remaining;
    args_total_next      = args_total;
    current_arg_next     = current_arg;
    bytes_remaining_next = bytes_remaining;
    res_fire             = 1'b0;
    res_next             = '0;

    unique case (phase) inside
      PH_IDLE: begin
        // skip CR/LF between requests; anything but '*' is fatal
        if ((in_b == CH_CR) || (in_b == CH_LF)) begin
        end else if (in_b != CH_STAR) begin
          phase_next          = PH_HALT;
          res_fire            = 1'b1;
          res_next.kind       = KIND_ERROR;
          res_next.error_code = ERR_NO_STAR;
        end else begin
          acc_next   = '0;
          flags_next = '0;
          phase_next = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (in_b != CH_LF) begin
          acc_next   = feed_acc;
          flags_next = feed_flags;
        end else if (flags.ovf || flags.neg || (acc == '0) ||
                     (acc > ACC_W'(MAX_ARGS))) begin
          phase_next          = PH_HALT;
          res_fire            = 1'b1;
          res_next.kind       = KIND_ERROR;
          res_next.error_code = ERR_BAD_CNT;
        end else begin
          args_total_next     = CNT_W'(acc);
          args_remaining_next = CNT_W'(acc);
          current_arg_next    = '0;
          phase_next          = PH_HFIRST;
        end
      end
      PH_OPTLF: begin
        if (in_b == CH_LF) begin
          phase_next = PH_HFIRST;
        end else begin
          // this byte is the dropped header character
          acc_next   = '0;
          flags_next = '0;
          phase_next = PH_HNUM;
        end
      end
      PH_HFIRST, PH_HNUM: begin
        if ((phase == PH_HNUM) && (in_b != CH_LF)) begin
          acc_next   = feed_acc;
          flags_next = feed_flags;
        end else if ((phase == PH_HFIRST) && (in_b != CH_LF)) begin
          acc_next   = '0;
          flags_next = '0;
          phase_next = PH_HNUM;
        end else begin
          // header line ends: check the length and start the argument
          acc_next   = hd_acc;
          flags_next = hd_flags;
          res_fire   = 1'b1;
          if (hd_neg) begin
            phase_next          = PH_HALT;
            res_next.kind       = KIND_ERROR;
            res_next.error_code = ERR_NEG_LEN;
          end else if (hd_flags.ovf || (hd_acc > ACC_W'(MAX_ARG_LEN))) begin
            phase_next          = PH_HALT;
            res_next.kind       = KIND_ERROR;
            res_next.error_code = ERR_LEN_BIG;
          end else begin
            bytes_remaining_next = LEN_W'(hd_acc);
            phase_next           = (hd_acc == '0) ? PH_TERM : PH_DATA;
            res_next.kind        = KIND_ARG_BEGIN;
            res_next.arg_length  = LEN_W'(hd_acc);
            res_next.arg_index   = current_arg;
          end
        end
      end
      PH_DATA: begin
        bytes_remaining_next = br_dec;
        res_fire             = 1'b1;
        res_next.kind        = KIND_ARG_DATA;
        res_next.data_byte   = in_b;
        res_next.arg_index   = current_arg;
        res_next.last_of_arg = (br_dec == '0);
        if (br_dec == '0) begin
          phase_next = PH_TERM;
        end
      end
      PH_TERM: begin
        // any byte terminates the argument
        args_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next         = PH_IDLE;
          current_arg_next   = '0;
          res_fire           = 1'b1;
          res_next.kind      = KIND_REQ_DONE;
          res_next.arg_count = args_total;
        end else begin
          current_arg_next = current_arg + IDX_W'(1);
          phase_next       = PH_OPTLF;
        end
      end
      PH_HALT: begin
        // drop everything until reset
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  // Input register: capture a byte whenever the slot is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (bytes.ready) begin
      in_v <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_b <= bytes.in_byte;
    end
  end

  // Parser state: advance only when the byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      acc             <= '0;
      flags           <= '0;
      args_remaining  <= '0;
      args_total      <= '0;
      current_arg     <= '0;
      bytes_remaining <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      acc             <= acc_next;
      flags           <= flags_next;
      args_remaining  <= args_remaining_next;
      args_total      <= args_total_next;
      current_arg     <= current_arg_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  // Result register: load on a producing step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= res_fire;
    end else if (events.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      res <= res_next;
    end
  end

  assign events.valid       = out_v;
  assign events.kind        = res.kind;
  assign events.data_byte   = res.data_byte;
  assign events.arg_length  = res.arg_length;
  assign events.arg_index   = res.arg_index;
  assign events.last_of_arg = res.last_of_arg;
  assign events.arg_count   = res.arg_count;
  assign events.error_code  = res.error_code;

  // Halt is final until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) |=> (phase == PH_HALT))
    else $error("deframer left halt without reset");

  // A pending error event only exists once the parser has halted
  a_error_halted: assert property (@(posedge clk) disable iff (rst)
    (out_v && (res.kind == KIND_ERROR)) |-> (phase == PH_HALT))
    else $error("error event without halt");

  // Inside a request the argument position stays below the count
  a_arg_in_range: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_HFIRST) || (phase == PH_HNUM) || (phase == PH_DATA) ||
     (phase == PH_TERM) || (phase == PH_OPTLF))
      |-> ({1'b0, current_arg} < args_total))
    else $error("argument index beyond request count");

  // The final data byte moves the parser to the terminator
  a_last_to_term: assert property (@(posedge clk) disable iff (rst)
    (advance && (phase == PH_DATA) && (bytes_remaining == LEN_W'(1)))
      |=> (phase == PH_TERM) && out_v && res.last_of_arg)
    else $error("last data byte did not end the argument");

endmodule

### rtl/core/mrd_num_digit.sv
// ----------------------------------------------------------------------------
// mrd_num_digit
// Feed one byte into a decimal number line: skip blanks, take a sign,
// accumulate digits with saturation, stop at the first other byte.
// ----------------------------------------------------------------------------
module mrd_num_digit (
  input  mrd_pkg::byte_t      b,
  input  mrd_pkg::acc_t       acc,
  input  mrd_pkg::num_flags_t flags,
  output mrd_pkg::acc_t       acc_next,
  output mrd_pkg::num_flags_t flags_next
);
  import mrd_pkg::*;

  logic              is_blank;
  logic              is_digit;
  logic [PROD_W-1:0] prod;

  assign is_blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
                    (b == CH_FF) || (b == CH_CR);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign prod     = PROD_W'(acc) * PROD_W'(RADIX) + PROD_W'(b - CH_ZERO);

  always_comb begin
    acc_next   = acc;
    flags_next = flags;
    if (!flags.stop) begin
      if (!flags.begun && is_blank) begin
        // skip leading blanks
      end else if (!flags.begun && (b == CH_PLUS)) begin
        flags_next.begun = 1'b1;
      end else if (!flags.begun && (b == CH_MINUS)) begin
        flags_next.begun = 1'b1;
        flags_next.neg   = 1'b1;
      end else if (is_digit) begin
        flags_next.begun = 1'b1;
        if (!flags.ovf) begin
          if (prod > PROD_W'(NUM_CAP)) begin
            flags_next.ovf = 1'b1;
            acc_next       = ACC_W'(NUM_CAP + 1);
          end else begin
            acc_next = prod[ACC_W-1:0];
          end
        end
      end else begin
        flags_next.stop = 1'b1;
      end
    end
  end

endmodule

### sim/tb_multibulk_request_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multibulk_request_deframer_top
// Self-checking bench for the multibulk request deframer: drives framed byte
// streams with random content and idling, predicts every event in a
// scoreboard, and ends on a single broken frame that halts the block.
// ----------------------------------------------------------------------------
module tb_multibulk_request_deframer_top;
  import mrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES   = 585;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_REPORTS   = 10;
  // Leading character of an argument header; the block drops it unchecked
  localparam byte_t BULK_MARK = "$";

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the deframer state byte by byte and holds the events
  // that the block still owes, oldest first.
  // --------------------------------------------------------------------------
  class deframer_scoreboard;
    phase_t           phase;
    acc_t             acc;
    num_flags_t       flags;
    logic [CNT_W-1:0] args_left;
    logic [CNT_W-1:0] args_total;
    logic [IDX_W-1:0] arg_pos;
    logic [LEN_W-1:0] bytes_left;
    result_t          expected_events[$];
    int unsigned      failures;

    function new();
      phase      = PH_IDLE;
      acc        = '0;
      flags      = '0;
      args_left  = '0;
      args_total = '0;
      arg_pos    = '0;
      bytes_left = '0;
      failures   = 0;
    endfunction

    function int unsigned pending();
      return $unsigned(expected_events.size());
    endfunction

    function void queue_event(result_t ev);
      expected_events.insert(expected_events.size(), ev);
    endfunction

    function string describe(result_t r);
      return $sformatf("kind=%0d byte=%02h len=%0d idx=%0d last=%0b count=%0d err=%0d",
                       r.kind, r.data_byte, r.arg_length, r.arg_index, r.last_of_arg,
                       r.arg_count, r.error_code);
    endfunction

    function void halt_with(err_t code);
      result_t ev;
      ev            = '0;
      ev.kind       = KIND_ERROR;
      ev.error_code = code;
      queue_event(ev);
      phase = PH_HALT;
    endfunction

    // Decimal line reader: skip blanks until a sign or digit, stop at the
    // first other byte, saturate just above the larger limit.
    function void accumulate_digit(byte_t b);
      logic [PROD_W-1:0] grown;
      if (flags.stop) return;
      if (!flags.begun) begin
        if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR) return;
        if (b == CH_PLUS) begin
          flags.begun = 1'b1;
          return;
        end
        if (b == CH_MINUS) begin
          flags.begun = 1'b1;
          flags.neg   = 1'b1;
          return;
        end
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
        flags.begun = 1'b1;
        if (!flags.ovf) begin
          grown = PROD_W'(acc) * PROD_W'(RADIX) + PROD_W'(b - CH_ZERO);
          if (grown > PROD_W'(NUM_CAP)) begin
            flags.ovf = 1'b1;
            acc       = ACC_W'(NUM_CAP + 1);
          end else begin
            acc = ACC_W'(grown);
          end
        end
      end else begin
        flags.stop = 1'b1;
      end
    endfunction

    function void close_header();
      result_t ev;
      if (flags.neg && acc != '0) begin
        halt_with(ERR_NEG_LEN);
      end else if (flags.ovf || 32'(acc) > MAX_ARG_LEN) begin
        halt_with(ERR_LEN_BIG);
      end else begin
        bytes_left    = LEN_W'(acc);
        phase         = (acc == '0) ? PH_TERM : PH_DATA;
        ev            = '0;
        ev.kind       = KIND_ARG_BEGIN;
        ev.arg_length = LEN_W'(acc);
        ev.arg_index  = arg_pos;
        queue_event(ev);
      end
    endfunction

    function void note_byte(byte_t b);
      result_t ev;
      case (phase)
        PH_IDLE: begin
          if (b != CH_CR && b != CH_LF) begin
            if (b != CH_STAR) begin
              halt_with(ERR_NO_STAR);
            end else begin
              acc   = '0;
              flags = '0;
              phase = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          if (b != CH_LF) begin
            accumulate_digit(b);
          end else if (flags.ovf || flags.neg || acc == '0 || 32'(acc) > MAX_ARGS) begin
            halt_with(ERR_BAD_CNT);
          end else begin
            args_total = CNT_W'(acc);
            args_left  = CNT_W'(acc);
            arg_pos    = '0;
            phase      = PH_HFIRST;
          end
        end
        PH_OPTLF: begin
          if (b == CH_LF) begin
            phase = PH_HFIRST;
          end else begin
            acc   = '0;
            flags = '0;
            phase = PH_HNUM;
          end
        end
        PH_HFIRST: begin
          acc   = '0;
          flags = '0;
          if (b == CH_LF) close_header();
          else phase = PH_HNUM;
        end
        PH_HNUM: begin
          if (b != CH_LF) accumulate_digit(b);
          else close_header();
        end
        PH_DATA: begin
          bytes_left     = bytes_left - LEN_W'(1);
          ev             = '0;
          ev.kind        = KIND_ARG_DATA;
          ev.data_byte   = b;
          ev.arg_index   = arg_pos;
          ev.last_of_arg = (bytes_left == '0);
          queue_event(ev);
          if (bytes_left == '0) phase = PH_TERM;
        end
        PH_TERM: begin
          args_left = args_left - CNT_W'(1);
          if (args_left == '0) begin
            phase        = PH_IDLE;
            arg_pos      = '0;
            ev           = '0;
            ev.kind      = KIND_REQ_DONE;
            ev.arg_count = args_total;
            queue_event(ev);
          end else begin
            arg_pos = arg_pos + IDX_W'(1);
            phase   = PH_OPTLF;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) $display("unexpected event: %s", describe(got));
        return;
      end
      want = expected_events.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.arg_length !== want.arg_length || got.arg_index !== want.arg_index ||
          got.last_of_arg !== want.last_of_arg || got.arg_count !== want.arg_count ||
          got.error_code !== want.error_code) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("event mismatch, expected: %s", describe(want));
          $display("                actual:   %s", describe(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mrd_byte_if  byte_ch ();
  mrd_event_if event_ch ();

  multibulk_request_deframer_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch.sink),
    .events (event_ch.source)
  );

  deframer_scoreboard frame_checker = new;

  // Idling controls, set by the stimulus process per phase
  int unsigned tx_idle_pct  = 17;
  int unsigned rx_stall_pct = 53;
  // Long receiver hold-off: the stimulus posts a length, the receiver counts it
  int unsigned hold_request = 0;
  int unsigned bytes_accepted = 0;
  int unsigned cycle_count = 0;

  byte_t   outgoing[$];
  result_t seen;

  // --------------------------------------------------------------------------
  // Monitor: all driving happens at the rising edge, so the values at the
  // falling edge are exactly what the next rising edge will accept. Note the
  // input request first; its event cannot leave in the same cycle anyway.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) frame_checker.note_byte(byte_ch.in_byte);
      if (event_ch.valid && event_ch.ready) begin
        seen.kind        = event_ch.kind;
        seen.data_byte   = event_ch.data_byte;
        seen.arg_length  = event_ch.arg_length;
        seen.arg_index   = event_ch.arg_index;
        seen.last_of_arg = event_ch.last_of_arg;
        seen.arg_count   = event_ch.arg_count;
        seen.error_code  = event_ch.error_code;
        frame_checker.check_event(seen);
      end
    end
  end

  // Watchdog: a hung handshake or a missing event ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall at random, or hold ready low for a posted stretch so the
  // block fills its result slot and backs up into the input side.
  // --------------------------------------------------------------------------
  initial begin : event_sink
    int unsigned hold_left;
    hold_left = 0;
    event_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        event_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        event_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic byte_t random_non_lf();
    byte_t c;
    c = CH_LF;
    while (c == CH_LF) c = byte_t'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic put_byte(input byte_t b);
    outgoing.insert(outgoing.size(), b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(byte_t'(s[i]));
  endtask

  // Offer one request; idle each cycle at random first, then hold valid until
  // it is taken. Called at a rising edge and returns at the edge that accepted
  // the request.
  task automatic send_byte(input byte_t b);
    bit taken;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = byte_ch.ready;
      @(posedge clk);
    end
    bytes_accepted++;
  endtask

  task automatic send_frame();
    while (outgoing.size() != 0) send_byte(outgoing.pop_front());
  endtask

  // Drop valid and wait until the block owes nothing, then let the pipeline
  // clear of requests that make no event.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (frame_checker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Decimal line in the loose forms the block accepts: leading blanks, a
  // sign, leading zeros, junk after the number. A zero length may also be
  // written with no digits or as minus zero.
  task automatic put_number_line(input int unsigned value, input bit length_line);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 4))
          0:       put_byte(CH_SPACE);
          1:       put_byte(CH_TAB);
          2:       put_byte(CH_VT);
          3:       put_byte(CH_FF);
          default: put_byte(CH_CR);
        endcase
      end
    end
    if (value == 0 && length_line) begin
      case ($urandom_range(0, 3))
        0:       put_text("");
        1:       put_text("-0");
        2:       put_text("+0");
        default: put_text("0");
      endcase
    end else begin
      if ($urandom_range(0, 3) == 0) put_byte(CH_PLUS);
      if ($urandom_range(0, 3) == 0) put_text("00");
      put_text($sformatf("%0d", value));
    end
    // A letter always ends the number; whatever follows up to LF is ignored
    if ($urandom_range(0, 4) == 0) begin
      put_byte(byte_t'($urandom_range(8'h61, 8'h7a)));
      repeat ($urandom_range(0, 3)) put_byte(random_non_lf());
    end else begin
      put_byte(CH_CR);
    end
    put_byte(CH_LF);
  endtask

  // Well-formed frame with random content: gap bytes, count line, then per
  // argument an optional LF, a header (or an empty one), data and terminator.
  task automatic build_frame();
    int unsigned n_args;
    int unsigned len;
    bit          lf_before;
    repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    put_byte(CH_STAR);
    n_args = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    put_number_line(n_args, 1'b0);
    lf_before = 1'b1;
    for (int a = 0; a < int'(n_args); a++) begin
      if (a != 0) begin
        // Without the optional LF the next byte is taken as the header mark
        lf_before = ($urandom_range(0, 3) != 0);
        if (lf_before) put_byte(CH_LF);
      end
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 16);
      if (lf_before && len == 0 && $urandom_range(0, 2) == 0) begin
        put_byte(CH_LF);
      end else begin
        put_byte(($urandom_range(0, 3) != 0) ? BULK_MARK : random_non_lf());
        put_number_line(len, 1'b1);
      end
      repeat (len) put_byte(byte_t'($urandom_range(0, 255)));
      put_byte(($urandom_range(0, 3) != 0) ? CH_CR : byte_t'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) != 0) put_byte(CH_LF);
  endtask

  // One broken frame, picked at random since the block halts for good on an
  // error; a valid frame and noise follow and must be dropped silently.
  task automatic build_broken_frame();
    int unsigned variant;
    string       count_text;
    string       len_text;
    byte_t       c;
    variant    = $urandom_range(0, 9);
    count_text = "1";
    len_text   = "";
    case (variant)
      1: count_text = "0";
      2: count_text = "-0";
      3: count_text = $sformatf("-%0d", $urandom_range(1, 99));
      4: count_text = $sformatf("%0d", MAX_ARGS + 1);
      5: count_text = "123456789012";
      6: count_text = "";
      7: len_text   = $sformatf("-%0d", $urandom_range(1, 99));
      8: len_text   = $sformatf("%0d", MAX_ARG_LEN + 1);
      default: len_text = $urandom_range(0, 1) ? "99999999999" : "-99999999999";
    endcase
    if (variant == 0) begin
      // Anything but a gap byte or a star opens the frame wrongly
      c = CH_STAR;
      while (c == CH_STAR || c == CH_CR || c == CH_LF) c = byte_t'($urandom_range(0, 255));
      put_byte(c);
    end else begin
      put_byte(CH_STAR);
      put_text(count_text);
      put_byte(CH_CR);
      put_byte(CH_LF);
      if (variant >= 7) begin
        put_byte(BULK_MARK);
        put_text(len_text);
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
    end
    put_byte(CH_STAR);
    put_text("1");
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(BULK_MARK);
    put_text("1z");
    put_byte(CH_CR);
    put_byte(CH_LF);
    repeat (8) put_byte(byte_t'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned goal;
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed frame: gap bytes, blank and plus before the count, an empty
    // header, a header straight after a terminator with minus zero, the
    // optional LF, and data bytes at both extremes.
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(CH_STAR);
    put_byte(CH_SPACE);
    put_byte(CH_PLUS);
    put_text("3");
    put_byte(CH_LF);
    put_byte(CH_LF);
    put_text("x");
    put_byte(BULK_MARK);
    put_byte(CH_MINUS);
    put_text("0");
    put_byte(CH_LF);
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(BULK_MARK);
    put_text("2");
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_CR);
    put_byte(CH_LF);
    send_frame();

    // Random frames in three idling phases; pause for a full drain between
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct  = 17;
          rx_stall_pct = 53;
        end
        1: begin
          tx_idle_pct  = 53;
          rx_stall_pct = 17;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          // Stall the receiver while requests keep coming at full rate
          hold_request = HOLD_CYCLES;
        end
      endcase
      goal = bytes_accepted + PHASE_BYTES;
      while (bytes_accepted < goal) begin
        build_frame();
        send_frame();
      end
      wait_drained();
    end

    build_broken_frame();
    send_frame();
    wait_drained();

    if (frame_checker.failures == 0 && frame_checker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
